@@ design/numeric_literal_parser_assert.svh @@
// assertion macros for the numeric literal parser
// used by numeric_literal_parser.sv; expects clk and rst in scope
`ifndef NUMERIC_LITERAL_PARSER_ASSERT_SVH
`define NUMERIC_LITERAL_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
// check outside reset
`define NLP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("numeric_literal_parser assertion failed");
// check at every edge, reset included
`define NLP_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("numeric_literal_parser assertion failed");
`else
`define NLP_ASSERT(label, prop)
`define NLP_ASSERT_ALWAYS(label, prop)
`endif

`endif

@@ design/nlp_pkg.sv @@
// shared types, character constants and digit helpers for the numeric literal parser
// no dependencies
`default_nettype none

package nlp_pkg;

  // width of the running values
  localparam int VALUE_WIDTH = 32;
  localparam int OUT_WIDTH   = 32;
  localparam int NUM_OFFSETS = 3;

  // character codes
  localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
  localparam logic [7:0] CHAR_HASH    = 8'h23;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_B = 8'h62;
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;
  localparam logic [7:0] CHAR_LOWER_H = 8'h68;
  localparam logic [7:0] CHAR_LOWER_X = 8'h78;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // digit code for a character that is no hex digit
  localparam logic [4:0] DIGIT_NONE = 5'd16;
  localparam logic [4:0] DIGIT_TEN  = 5'd10;
  localparam logic [4:0] DIGIT_TWO  = 5'd2;

  // positions in the digit valid flags
  localparam int FLAG_HEX0  = 0;
  localparam int FLAG_BIN0  = 3;
  localparam int FLAG_DEC   = 6;
  localparam int FLAG_HEXBL = 7;
  localparam int FLAG_BINBL = 8;
  localparam int NUM_FLAGS  = 9;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_token;
  } char_item_t;

  typedef struct packed {
    logic                 is_literal;
    logic [OUT_WIDTH-1:0] literal_value;
  } res_item_t;

  // token state after taking the current character
  typedef struct packed {
    logic [1:0]                   pos;
    logic [7:0]                   first_char;
    logic [7:0]                   second_char;
    logic [7:0]                   last_char;
    logic [NUM_OFFSETS-1:0][VALUE_WIDTH-1:0] hex_acc;
    logic [NUM_OFFSETS-1:0][VALUE_WIDTH-1:0] bin_acc;
    value_t                       dec_acc;
    value_t                       hex_bl;
    value_t                       bin_bl;
    logic [NUM_FLAGS-1:0]         flags;
  } acc_view_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

  // hex digit value, or DIGIT_NONE
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [7:0] l;
    logic [7:0] t;
    l = to_lower(c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      t = c - CHAR_ZERO;
      return t[4:0];
    end
    if (l >= CHAR_LOWER_A && l <= CHAR_LOWER_F) begin
      t = l - CHAR_LOWER_A + 8'd10;
      return t[4:0];
    end
    return DIGIT_NONE;
  endfunction

endpackage

`default_nettype wire

@@ design/nlp_accum.sv @@
// token state: position, saved characters, digit accumulators and valid flags
// depends on nlp_pkg
`default_nettype none

module nlp_accum
  import nlp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire char_item_t item,
  output acc_view_t       view
);

  logic [1:0]           pos;
  logic [7:0]           first_char;
  logic [7:0]           second_char;
  logic [NUM_OFFSETS-1:0][VALUE_WIDTH-1:0] hex_acc;
  logic [NUM_OFFSETS-1:0][VALUE_WIDTH-1:0] bin_acc;
  value_t               dec_acc;
  logic [NUM_FLAGS-1:0] flags;

  logic [4:0]           digit;
  value_t               digit_ext;
  logic                 hex_ok;
  logic                 bin_ok;
  logic                 dec_ok;
  acc_view_t            view_next;

  // classify the character
  always_comb begin
    digit     = digit_of(item.char_code);
    digit_ext = {{(VALUE_WIDTH-5){1'b0}}, digit};
    hex_ok    = !digit[4];
    bin_ok    = digit < DIGIT_TWO;
    dec_ok    = digit < DIGIT_TEN;
  end

  // state with the current character folded in
  always_comb begin
    view_next             = '0;
    view_next.pos         = pos;
    view_next.last_char   = item.char_code;
    view_next.first_char  = (pos == 2'd0) ? item.char_code : first_char;
    view_next.second_char = (pos == 2'd1) ? item.char_code : second_char;
    view_next.hex_bl      = hex_acc[0];
    view_next.bin_bl      = bin_acc[0];
    view_next.flags       = flags;
    view_next.flags[FLAG_HEXBL] = flags[FLAG_HEX0];
    view_next.flags[FLAG_BINBL] = flags[FLAG_BIN0];
    for (int k = 0; k < NUM_OFFSETS; k++) begin
      view_next.hex_acc[k] = hex_acc[k];
      view_next.bin_acc[k] = bin_acc[k];
      if (pos >= 2'(k)) begin
        if (hex_ok) begin
          view_next.hex_acc[k] = {hex_acc[k][VALUE_WIDTH-5:0], digit[3:0]};
        end else begin
          view_next.flags[FLAG_HEX0+k] = 1'b0;
        end
        if (bin_ok) begin
          view_next.bin_acc[k] = {bin_acc[k][VALUE_WIDTH-2:0], digit[0]};
        end else begin
          view_next.flags[FLAG_BIN0+k] = 1'b0;
        end
      end
    end
    // times ten as two shifts and an add
    if (dec_ok) begin
      view_next.dec_acc = {dec_acc[VALUE_WIDTH-4:0], 3'b000}
                        + {dec_acc[VALUE_WIDTH-2:0], 1'b0} + digit_ext;
    end else begin
      view_next.dec_acc = dec_acc;
      view_next.flags[FLAG_DEC] = 1'b0;
    end
  end

  assign view = view_next;

  // state registers; cleared at reset and after the last character
  always_ff @(posedge clk) begin
    if (rst || (step && item.end_of_token)) begin
      pos         <= '0;
      first_char  <= '0;
      second_char <= '0;
      hex_acc     <= '0;
      bin_acc     <= '0;
      dec_acc     <= '0;
      flags       <= '1;
    end else if (step) begin
      pos         <= (pos == 2'd3) ? pos : pos + 2'd1;
      first_char  <= view_next.first_char;
      second_char <= view_next.second_char;
      hex_acc     <= view_next.hex_acc;
      bin_acc     <= view_next.bin_acc;
      dec_acc     <= view_next.dec_acc;
      flags       <= view_next.flags;
    end
  end

endmodule

`default_nettype wire

@@ design/nlp_select.sv @@
// picks the literal form of a finished token and its value
// depends on nlp_pkg
`default_nettype none

module nlp_select
  import nlp_pkg::*;
(
  input  acc_view_t view,
  output res_item_t res
);

  logic [7:0]                   second_lc;
  logic [7:0]                   last_lc;
  logic                         ok;
  value_t                       val;
  logic [VALUE_WIDTH+OUT_WIDTH-1:0] val_ext;

  // forms are tried in a fixed order
  always_comb begin
    second_lc = to_lower(view.second_char);
    last_lc   = to_lower(view.last_char);
    if (view.first_char == CHAR_DOLLAR || view.first_char == CHAR_HASH) begin
      ok  = (view.pos != 2'd0) && view.flags[FLAG_HEX0+1];
      val = view.hex_acc[1];
    end else if (view.first_char == CHAR_PERCENT) begin
      ok  = (view.pos != 2'd0) && view.flags[FLAG_BIN0+1];
      val = view.bin_acc[1];
    end else if (view.pos == 2'd0) begin
      ok  = view.flags[FLAG_DEC];
      val = view.dec_acc;
    end else if (last_lc == CHAR_LOWER_H) begin
      ok  = view.flags[FLAG_HEXBL];
      val = view.hex_bl;
    end else if (view.first_char == CHAR_ZERO && second_lc == CHAR_LOWER_X) begin
      ok  = view.flags[FLAG_HEX0+2];
      val = view.hex_acc[2];
    end else if (view.first_char == CHAR_ZERO && second_lc == CHAR_LOWER_B) begin
      ok  = view.flags[FLAG_BIN0+2];
      val = view.bin_acc[2];
    end else if (last_lc == CHAR_LOWER_B) begin
      ok  = view.flags[FLAG_BINBL];
      val = view.bin_bl;
    end else begin
      ok  = view.flags[FLAG_DEC];
      val = view.dec_acc;
    end
  end

  // fit the running value to the result width
  always_comb begin
    val_ext           = {{OUT_WIDTH{1'b0}}, val};
    res.is_literal    = ok;
    res.literal_value = ok ? val_ext[OUT_WIDTH-1:0] : '0;
  end

endmodule

`default_nettype wire

@@ design/numeric_literal_parser.sv @@
// top level of the numeric literal parser: input register, token state, result register
// depends on nlp_pkg, nlp_accum, nlp_select and numeric_literal_parser_assert.svh
`default_nettype none

// Takes one character of a token per item, end_of_token set on the last one,
// and returns one result item per token: whether the token is a numeric
// literal ($ # % prefixes, h and b suffixes, 0x and 0b prefixes, decimal) and
// its value modulo 2^32. One character is accepted every cycle while no last
// character waits in the input register on a stalled result; the token state
// (digit runs at offsets 0 to 2 plus decimal) is updated from the input
// register, and the result register takes the result as the last character
// leaves the input register, then holds a finished result while the next
// characters keep flowing. Only a stalled result blocks a further last character.
`include "numeric_literal_parser_assert.svh"

module numeric_literal_parser
  import nlp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       char_valid,
  output logic            char_ready,
  input  wire char_item_t char_item,
  output logic            res_valid,
  input  wire logic       res_ready,
  output res_item_t       res_item
);

  logic       s1_valid;
  char_item_t s1_item;
  logic       out_free;
  logic       s1_fire;
  acc_view_t  view;
  res_item_t  res_next;

  // handshake: a last character needs a free result register
  assign out_free   = !res_valid || res_ready;
  assign s1_fire    = s1_valid && (!s1_item.end_of_token || out_free);
  assign char_ready = !s1_valid || s1_fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (char_ready) begin
      s1_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_ready && char_valid) begin
      s1_item <= char_item;
    end
  end

  nlp_accum u_accum (
    .clk  (clk),
    .rst  (rst),
    .step (s1_fire),
    .item (s1_item),
    .view (view)
  );

  nlp_select u_select (
    .view (view),
    .res  (res_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire && s1_item.end_of_token) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_item.end_of_token) begin
      res_item <= res_next;
    end
  end

  // checks
  `NLP_ASSERT_ALWAYS(a_reset_empties, rst |=> !res_valid && !s1_valid)
  `NLP_ASSERT(a_res_from_last, $rose(res_valid) |-> $past(s1_valid && s1_item.end_of_token))
  `NLP_ASSERT(a_mid_char_drains, (s1_valid && !s1_item.end_of_token) |-> char_ready)
  `NLP_ASSERT(a_no_literal_zero, (res_valid && !res_item.is_literal) |-> (res_item.literal_value == '0))

endmodule

`default_nettype wire

@@ sim/tb_numeric_literal_parser.sv @@
// self-checking testbench for numeric_literal_parser: token stimulus, literal predictor, checker
// depends on nlp_pkg and the numeric_literal_parser rtl
module tb_numeric_literal_parser;
  import nlp_pkg::*;

  localparam int NUM_RANDOM    = 700;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;

  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_EVERY_FOURTH,
    READY_RARE
  } stall_mode_t;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       char_valid = 1'b0;
  logic       char_ready;
  char_item_t char_item  = '0;
  logic       res_valid;
  logic       res_ready  = 1'b0;
  res_item_t  res_item;

  numeric_literal_parser u_dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_item   (res_item)
  );

  // clock and reset
  always #6 clk = ~clk;

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // stimulus and scoreboard storage
  char_item_t pending_chars[$];
  res_item_t  expected_literals[$];
  int         drain_points[$];
  logic [7:0] tok_buf[$];
  string      hex_set = "0123456789abcdefABCDEF";

  // predictor state for the token in progress
  logic [1:0]           tok_len;
  logic [7:0]           tok_first;
  logic [7:0]           tok_second;
  value_t               hex_run [NUM_OFFSETS];
  value_t               bin_run [NUM_OFFSETS];
  value_t               dec_run;
  value_t               hex_prev;
  value_t               bin_prev;
  logic [NUM_FLAGS-1:0] run_ok;

  int          chars_in     = 0;
  int          tokens_out   = 0;
  int          literals_out = 0;
  int          fail_count   = 0;
  int          cycle_count  = 0;
  int          burst_left   = 0;
  int          gap_left     = 0;
  int          mode_left    = 0;
  int          phase_cnt    = 0;
  stall_mode_t ready_mode   = READY_ALWAYS;

  // ---------------------------------------------------------------------------
  // literal predictor

  function automatic logic [7:0] fold_case(input logic [7:0] ch);
    if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
      return ch | CASE_OFFSET;
    end
    return ch;
  endfunction

  // hex digit weight, DIGIT_NONE for anything else
  function automatic logic [4:0] digit_value(input logic [7:0] ch);
    logic [7:0] lc;
    logic [7:0] off;
    lc = fold_case(ch);
    if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
      off = ch - CHAR_ZERO;
      return off[4:0];
    end
    if (lc >= CHAR_LOWER_A && lc <= CHAR_LOWER_F) begin
      off = lc - CHAR_LOWER_A;
      return off[4:0] + DIGIT_TEN;
    end
    return DIGIT_NONE;
  endfunction

  task automatic restart_token();
    int k;
    tok_len    = '0;
    tok_first  = '0;
    tok_second = '0;
    for (k = 0; k < NUM_OFFSETS; k++) begin
      hex_run[k] = '0;
      bin_run[k] = '0;
    end
    dec_run  = '0;
    hex_prev = '0;
    bin_prev = '0;
    run_ok   = '1;
  endtask

  // advance the token state by one character; on the last one queue the result
  task automatic parse_char(input char_item_t it);
    logic [4:0] dv;
    logic [1:0] pos;
    logic [7:0] last_lc;
    logic [7:0] second_lc;
    logic       good;
    value_t     val;
    res_item_t  res;
    int         k;
    pos = tok_len;
    dv  = digit_value(it.char_code);
    // offset-0 runs as they stood before this character
    hex_prev           = hex_run[0];
    bin_prev           = bin_run[0];
    run_ok[FLAG_HEXBL] = run_ok[FLAG_HEX0];
    run_ok[FLAG_BINBL] = run_ok[FLAG_BIN0];
    // every run that has started by now takes the character
    for (k = 0; k < NUM_OFFSETS; k++) begin
      if (pos >= k) begin
        if (dv < DIGIT_NONE) begin
          hex_run[k] = {hex_run[k][VALUE_WIDTH-5:0], dv[3:0]};
        end else begin
          run_ok[FLAG_HEX0 + k] = 1'b0;
        end
        if (dv < DIGIT_TWO) begin
          bin_run[k] = {bin_run[k][VALUE_WIDTH-2:0], dv[0]};
        end else begin
          run_ok[FLAG_BIN0 + k] = 1'b0;
        end
      end
    end
    if (dv < DIGIT_TEN) begin
      dec_run = dec_run * 10 + dv;
    end else begin
      run_ok[FLAG_DEC] = 1'b0;
    end
    if (pos == 2'd0) tok_first = it.char_code;
    if (pos == 2'd1) tok_second = it.char_code;
    if (pos != 2'd3) tok_len = pos + 2'd1;
    if (!it.end_of_token) return;

    // pick the form: prefixes, lone character, suffix h, 0x / 0b, suffix b, decimal
    last_lc   = fold_case(it.char_code);
    second_lc = fold_case(tok_second);
    if (tok_first == CHAR_DOLLAR || tok_first == CHAR_HASH) begin
      good = (pos != 2'd0) && run_ok[FLAG_HEX0 + 1];
      val  = hex_run[1];
    end else if (tok_first == CHAR_PERCENT) begin
      good = (pos != 2'd0) && run_ok[FLAG_BIN0 + 1];
      val  = bin_run[1];
    end else if (pos == 2'd0) begin
      good = run_ok[FLAG_DEC];
      val  = dec_run;
    end else if (last_lc == CHAR_LOWER_H) begin
      good = run_ok[FLAG_HEXBL];
      val  = hex_prev;
    end else if (tok_first == CHAR_ZERO && second_lc == CHAR_LOWER_X) begin
      good = run_ok[FLAG_HEX0 + 2];
      val  = hex_run[2];
    end else if (tok_first == CHAR_ZERO && second_lc == CHAR_LOWER_B) begin
      good = run_ok[FLAG_BIN0 + 2];
      val  = bin_run[2];
    end else if (last_lc == CHAR_LOWER_B) begin
      good = run_ok[FLAG_BINBL];
      val  = bin_prev;
    end else begin
      good = run_ok[FLAG_DEC];
      val  = dec_run;
    end
    res.is_literal    = good;
    res.literal_value = good ? val : '0;
    expected_literals.push_back(res);
    restart_token();
  endtask

  // ---------------------------------------------------------------------------
  // token builders

  function automatic logic [7:0] any_char();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] hex_char();
    return hex_set[$urandom_range(0, 21)];
  endfunction

  function automatic logic [7:0] dec_char();
    return 8'(CHAR_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] bin_char();
    return 8'(CHAR_ZERO + $urandom_range(0, 1));
  endfunction

  // letter in random case
  function automatic logic [7:0] any_case(input logic [7:0] c);
    return $urandom_range(0, 1) ? (c & ~CASE_OFFSET) : c;
  endfunction

  // mostly short digit runs, now and then a longer one that can wrap
  function automatic int run_length(input int longest);
    if ($urandom_range(0, 7) == 0) return $urandom_range(9, longest);
    return $urandom_range(0, 8);
  endfunction

  task automatic add_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) tok_buf.push_back(s[i]);
  endtask

  // move the buffered token into the pending items, last character marked
  task automatic close_token();
    char_item_t it;
    int         i;
    for (i = 0; i < tok_buf.size(); i++) begin
      it.char_code    = tok_buf[i];
      it.end_of_token = (i == tok_buf.size() - 1);
      pending_chars.push_back(it);
    end
    tok_buf.delete();
  endtask

  task automatic build_form(input int form);
    int n;
    case (form)
      0: begin
        tok_buf.push_back($urandom_range(0, 1) ? CHAR_DOLLAR : CHAR_HASH);
        repeat (run_length(12)) tok_buf.push_back(hex_char());
      end
      1: begin
        tok_buf.push_back(CHAR_PERCENT);
        repeat (run_length(40)) tok_buf.push_back(bin_char());
      end
      2: tok_buf.push_back($urandom_range(0, 1) ? dec_char() : any_char());
      3: begin
        repeat (run_length(12)) tok_buf.push_back(hex_char());
        tok_buf.push_back(any_case(CHAR_LOWER_H));
      end
      4: begin
        tok_buf.push_back(CHAR_ZERO);
        tok_buf.push_back(any_case(CHAR_LOWER_X));
        repeat (run_length(12)) tok_buf.push_back(hex_char());
      end
      5: begin
        tok_buf.push_back(CHAR_ZERO);
        tok_buf.push_back(any_case(CHAR_LOWER_B));
        repeat (run_length(40)) tok_buf.push_back(bin_char());
      end
      6: begin
        repeat (run_length(40)) tok_buf.push_back(bin_char());
        tok_buf.push_back(any_case(CHAR_LOWER_B));
      end
      7: repeat (1 + run_length(14)) tok_buf.push_back(dec_char());
      8: begin
        // hex digits ending in b: the b suffix rejects any that are not binary
        repeat (run_length(10)) tok_buf.push_back(hex_char());
        tok_buf.push_back(any_case(CHAR_LOWER_B));
      end
      9: begin
        // 0b prefix with h suffix: the suffix wins
        tok_buf.push_back(CHAR_ZERO);
        tok_buf.push_back(any_case(CHAR_LOWER_B));
        repeat (run_length(10)) tok_buf.push_back(bin_char());
        tok_buf.push_back(any_case(CHAR_LOWER_H));
      end
      default: begin
        // raw noise
        n = $urandom_range(1, 6);
        repeat (n) tok_buf.push_back(any_char());
      end
    endcase
  endtask

  task automatic random_token();
    int form;
    form = $urandom_range(0, 12);
    if (form == 11) begin
      // well-formed token with one character replaced
      build_form($urandom_range(0, 9));
      tok_buf[$urandom_range(0, tok_buf.size() - 1)] = any_char();
    end else begin
      build_form(form);
    end
    close_token();
  endtask

  initial begin : stimulus
    int directed_len;
    bit mid_drain;
    mid_drain = 1'b0;
    // directed tokens: bare prefixes, each form, lone letter, empty runs, code extremes
    add_str("$");   close_token();
    add_str("#f");  close_token();
    add_str("%1");  close_token();
    add_str("%");   close_token();
    add_str("7");   close_token();
    add_str("a");   close_token();
    add_str("Fh");  close_token();
    add_str("0x");  close_token();
    add_str("0B1"); close_token();
    add_str("1b");  close_token();
    add_str("99");  close_token();
    tok_buf.push_back(8'hff);
    close_token();
    tok_buf.push_back(8'h00);
    add_str("1");
    close_token();
    directed_len = pending_chars.size();
    drain_points.push_back(directed_len);
    // random tokens, one more full drain halfway through
    while (pending_chars.size() < directed_len + NUM_RANDOM) begin
      random_token();
      if (!mid_drain && pending_chars.size() >= directed_len + NUM_RANDOM / 2) begin
        drain_points.push_back(pending_chars.size());
        mid_drain = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // character driver: bursts with random gaps, holds at drain points

  always @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
      restart_token();
    end else begin
      if (char_valid && char_ready) begin
        parse_char(char_item);
        chars_in++;
      end
      if (!char_valid || char_ready) begin
        if (drain_points.size() != 0 && chars_in == drain_points[0] &&
            expected_literals.size() == 0) begin
          drain_points.pop_front();
        end
        if (pending_chars.size() == 0 || gap_left > 0 ||
            (drain_points.size() != 0 && chars_in == drain_points[0])) begin
          char_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          char_valid <= 1'b1;
          char_item  <= pending_chars.pop_front();
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor and checker

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_result(input res_item_t got);
    res_item_t want;
    tokens_out++;
    if (got.is_literal) literals_out++;
    if (expected_literals.size() == 0) begin
      note_failure($sformatf("unexpected result is_literal=%0b literal_value=%h",
                             got.is_literal, got.literal_value));
      return;
    end
    want = expected_literals.pop_front();
    if (got.is_literal !== want.is_literal) begin
      note_failure($sformatf("token %0d is_literal expected %0b got %0b",
                             tokens_out, want.is_literal, got.is_literal));
    end
    if (got.literal_value !== want.literal_value) begin
      note_failure($sformatf("token %0d literal_value expected %h got %h",
                             tokens_out, want.literal_value, got.literal_value));
    end
  endtask

  // receiver stalls follow a mode that is picked at random
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
      mode_left = 0;
    end else begin
      if (res_valid && res_ready) check_result(res_item);
      if (mode_left == 0) begin
        ready_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(1, 40);
      end
      mode_left--;
      phase_cnt++;
      case (ready_mode)
        READY_ALWAYS:       res_ready <= 1'b1;
        READY_COIN:         res_ready <= 1'($urandom_range(0, 1));
        READY_EVERY_FOURTH: res_ready <= (phase_cnt % 4 == 0);
        default:            res_ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // run limit and end of test

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_literals.size());
      $display("numeric_literal_parser regression: fail");
      $finish;
    end
  end

  initial begin : finish_run
    while (rst || pending_chars.size() != 0 || char_valid || expected_literals.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d characters in %0d tokens, %0d parsed as literals, %0d failures",
             chars_in, tokens_out, literals_out, fail_count);
    if (fail_count == 0) begin
      $display("numeric_literal_parser regression: pass");
    end else begin
      $display("numeric_literal_parser regression: fail");
    end
    $finish;
  end

endmodule
